FILE: rtl/mfre_pkg.sv
// Shared types, request codes and the per-byte pixel function of the framebuffer row engine.
// No dependencies; imported by mono_framebuffer_row_engine.
`default_nettype none

package mfre_pkg;

  // Request codes carried in the req_type field
  localparam logic [1:0] REQ_XOR   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_FILL  = 2'd2;

  localparam logic [7:0] PIX_WHITE = 8'hFF;
  localparam int         MAX_EMIT  = 16;
  localparam int         GLYPH_W   = 32;
  // Column numbers of a row: up to 128 bytes of 8 pixels
  localparam int         COL_W     = 10;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_RUN
  } st_t;

  typedef struct packed {
    logic [7:0] line_number;
    logic [3:0] byte_index;
    logic [7:0] byte_value;
    logic       row_end;
  } out_item_t;

  // New value of one framebuffer byte whose leftmost pixel sits at column col0.
  // g_al holds the glyph left-aligned: its first pixel is bit 31.
  function automatic logic [7:0] mfre_new_byte(
    input logic [1:0]       req,
    input logic [7:0]       old_byte,
    input logic [COL_W-1:0] col0,
    input logic [6:0]       off,
    input logic [8:0]       hi,
    input logic [31:0]      g_al
  );
    logic [47:0]      ext;
    logic [10:0]      lim;
    logic [10:0]      sh;
    logic [7:0]       xmask;
    logic [7:0]       cmask;
    logic [COL_W:0]   col;
    logic [7:0]       res;
    ext   = {8'h00, g_al, 8'h00};
    lim   = 11'(off) + 11'd32;
    sh    = lim - 11'(col0);
    xmask = (11'(col0) < lim) ? 8'(ext >> sh) : 8'h00;
    for (int i = 0; i < 8; i++) begin
      col          = (COL_W+1)'(col0) + (COL_W+1)'(i);
      cmask[7 - i] = (col >= (COL_W+1)'(off)) && (col < (COL_W+1)'(hi));
    end
    case (req)
      REQ_XOR:   res = old_byte ^ xmask;
      REQ_CLEAR: res = old_byte & ~cmask;
      REQ_FILL:  res = PIX_WHITE;
      default:   res = old_byte;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mfre_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module mfre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mono_framebuffer_row_engine.sv
// Monochrome framebuffer row engine: top level with the frame store and the row sequencer.
// Depends on mfre_pkg and mfre_ram.
`default_nettype none

// Keeps a 1-bit-per-pixel framebuffer of ROW_COUNT rows of ROW_BYTES bytes in one RAM
// (MSB of each byte is the leftmost pixel, a set bit is white). Each input transfer is one
// operation on one row: XOR a glyph row of up to 32 pixels in at any column, clear a span
// of pixels to black, or fill the row white; an unused request code leaves the row alone.
// A line at or beyond ROW_COUNT is taken and dropped. With send set, the row is then
// emitted as one output transfer per byte (at most 16), numbered line+1, with row_end on
// the final one. After reset a sweep writes 0xFF to every RAM entry, one per cycle;
// in_stall stays high meanwhile. An operation walks the row through the single RAM read
// port, one byte per cycle while the output queue has room, and writes each modified
// byte back in the next cycle. A two-entry output queue lets a result wait while the
// walk carries on; the walk pauses when that queue is full.
module mono_framebuffer_row_engine
  import mfre_pkg::*;
#(
  parameter int ROW_BYTES = 16,
  parameter int ROW_COUNT = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Row operation channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [6:0]  in_line,
  input  wire logic [6:0]  in_bit_offset,
  input  wire logic [7:0]  in_span_bits,
  input  wire logic [31:0] in_glyph_bits,
  input  wire logic        in_send,
  // Row byte channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_line_number,
  output logic [3:0]       out_byte_index,
  output logic [7:0]       out_byte_value,
  output logic             out_row_end
);

  localparam int DEPTH = ROW_COUNT * ROW_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = $clog2(ROW_BYTES + 1);
  localparam int NB    = (ROW_BYTES > MAX_EMIT) ? MAX_EMIT : ROW_BYTES;

  // Sequencer state
  st_t             st_r, st_nxt;
  logic [AW-1:0]   sweep_addr_r;

  // Operation held for the length of one row walk
  logic [1:0]      req_r;
  logic [6:0]      line_r;
  logic [6:0]      off_r;
  logic [8:0]      hi_r;
  logic [31:0]     g_al_r;
  logic            send_r;
  logic [AW-1:0]   row_base_r;

  // Read issue and the byte returning from the RAM
  logic [BW-1:0]   rd_idx_r;
  logic            dp_valid_r;
  logic            dp_emit_r;
  logic [BW-1:0]   dp_idx_r;
  logic [AW-1:0]   dp_addr_r;

  // Output queue
  out_item_t       q_r [2];
  logic            q_wr_r, q_rd_r;
  logic [1:0]      q_cnt_r;

  logic            accept;
  logic            line_ok;
  logic            issue;
  logic            room;
  logic            pop;
  logic            push;
  logic            rd_done;
  logic            sweep_last;
  logic [2:0]      occ;
  logic [5:0]      glyph_n;
  logic [7:0]      rdata;
  logic [7:0]      new_byte;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic [AW-1:0]   ram_raddr;
  out_item_t       push_item;

  // ---------------------------------------------------------------- frame store
  mfre_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // ---------------------------------------------------------------- control decode
  assign accept     = in_valid && !in_stall;
  assign line_ok    = int'(in_line) < ROW_COUNT;
  assign rd_done    = (rd_idx_r == BW'(ROW_BYTES));
  assign sweep_last = (sweep_addr_r == AW'(DEPTH - 1));
  assign pop        = out_valid && !out_stall;
  assign push       = dp_valid_r && dp_emit_r;

  // Results already queued or on their way; leave a slot for the byte about to be read
  assign occ  = 3'(q_cnt_r) + 3'(push);
  assign room = !send_r || (occ < (3'd2 + 3'(pop)));

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_SWEEP: begin
        if (sweep_last) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && line_ok) begin
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // The last write-back lands in this cycle; the next read cannot come before it
        if (rd_done) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall  = 1'b1;
    issue     = 1'b0;
    ram_we    = dp_valid_r;
    ram_waddr = dp_addr_r;
    ram_wdata = new_byte;
    case (st_r)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr_r;
        ram_wdata = PIX_WHITE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_RUN: begin
        issue = !rd_done && room;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign ram_raddr = row_base_r + AW'(rd_idx_r);

  // ---------------------------------------------------------------- pixel update
  assign new_byte = mfre_new_byte(req_r, rdata, COL_W'(dp_idx_r) << 3, off_r, hi_r, g_al_r);

  // Glyph width saturates at 32 pixels
  assign glyph_n = (in_span_bits > 8'(GLYPH_W)) ? 6'(GLYPH_W) : 6'(in_span_bits);

  always_comb begin
    push_item.line_number = 8'(line_r) + 8'd1;
    push_item.byte_index  = 4'(dp_idx_r);
    push_item.byte_value  = new_byte;
    push_item.row_end     = (dp_idx_r == BW'(NB - 1));
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_SWEEP;
      sweep_addr_r <= '0;
      rd_idx_r     <= '0;
      dp_valid_r   <= 1'b0;
      q_wr_r       <= 1'b0;
      q_rd_r       <= 1'b0;
      q_cnt_r      <= 2'd0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_SWEEP) begin
        sweep_addr_r <= sweep_addr_r + AW'(1);
      end
      // Restart the walk on a new row, advance it one byte per read
      if (accept) begin
        rd_idx_r <= '0;
      end else if (issue) begin
        rd_idx_r <= rd_idx_r + BW'(1);
      end
      dp_valid_r <= issue;
      if (push) begin
        q_wr_r <= !q_wr_r;
      end
      if (pop) begin
        q_rd_r <= !q_rd_r;
      end
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= in_req_type;
      line_r     <= in_line;
      off_r      <= in_bit_offset;
      hi_r       <= 9'(in_bit_offset) + 9'(in_span_bits);
      g_al_r     <= in_glyph_bits << (6'(GLYPH_W) - glyph_n);
      send_r     <= in_send;
      row_base_r <= AW'(int'(in_line) * ROW_BYTES);
    end
    if (issue) begin
      dp_idx_r  <= rd_idx_r;
      dp_addr_r <= ram_raddr;
      dp_emit_r <= send_r && (int'(rd_idx_r) < MAX_EMIT);
    end
    if (push) begin
      q_r[q_wr_r] <= push_item;
    end
  end

  // ---------------------------------------------------------------- result port
  assign out_valid       = (q_cnt_r != 2'd0);
  assign out_line_number = q_r[q_rd_r].line_number;
  assign out_byte_index  = q_r[q_rd_r].byte_index;
  assign out_byte_value  = q_r[q_rd_r].byte_value;
  assign out_row_end     = q_r[q_rd_r].row_end;

endmodule

`default_nettype wire

FILE: tb/tb_mono_framebuffer_row_engine.sv
// Self-checking testbench for mono_framebuffer_row_engine: directed and random row operations.
// Depends on mfre_pkg (request codes, out_item_t) and the engine RTL, which also needs mfre_ram.
`default_nettype none

module tb_mono_framebuffer_row_engine
  import mfre_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_BYTES  = 16;
  localparam int ROW_COUNT  = 128;
  localparam int ROW_PIXELS = ROW_BYTES * 8;
  localparam int EMIT_BYTES = (ROW_BYTES > MAX_EMIT) ? MAX_EMIT : ROW_BYTES;
  // The one request code the package leaves unnamed: it must leave the row alone
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Generous bound: the clearing sweep plus every item sending 16 stalled bytes, many times over
  localparam int CYCLE_LIMIT = 400000;
  // Quiet cycles after the last expected byte, to catch stray transfers
  localparam int TAIL_CYCLES = 3 * (ROW_BYTES + 2);

  // Shadow copy of the framebuffer and the row bytes it predicts, oldest first
  class frame_tracker;
    bit [7:0]  frame [ROW_COUNT][ROW_BYTES];
    out_item_t row_bytes_due [$];
    int        errors;

    function new();
      foreach (frame[r, b]) frame[r][b] = PIX_WHITE;
      errors = 0;
    endfunction

    function int pending();
      return row_bytes_due.size();
    endfunction

    // Apply one accepted row operation to the shadow frame; queue the bytes it emits
    function void note_op(logic [1:0] req, logic [6:0] line, logic [6:0] off,
                          logic [7:0] span, logic [31:0] glyph, logic send);
      int        n;
      int        col;
      out_item_t item;
      if (int'(line) >= ROW_COUNT) return;
      case (req)
        REQ_XOR: begin
          n = (span > 8'd32) ? 32 : int'(span);
          // Glyph bit n-1-k lands on column off+k; drop anything past the row end
          for (int k = 0; k < n; k++) begin
            col = int'(off) + k;
            if (glyph[n - 1 - k] && col < ROW_PIXELS)
              frame[line][col / 8] ^= 8'h80 >> (col % 8);
          end
        end
        REQ_CLEAR: begin
          for (int k = 0; k < int'(span); k++) begin
            col = int'(off) + k;
            if (col < ROW_PIXELS)
              frame[line][col / 8] &= ~(8'h80 >> (col % 8));
          end
        end
        REQ_FILL: begin
          for (int b = 0; b < ROW_BYTES; b++) frame[line][b] = PIX_WHITE;
        end
        default: ;
      endcase
      if (send) begin
        for (int b = 0; b < EMIT_BYTES; b++) begin
          item.line_number = 8'(line) + 8'd1;
          item.byte_index  = 4'(b);
          item.byte_value  = frame[line][b];
          item.row_end     = (b == EMIT_BYTES - 1);
          row_bytes_due.push_back(item);
        end
      end
    endfunction

    // Compare one transferred row byte with the oldest prediction
    function void check_byte(out_item_t got);
      out_item_t want;
      if (row_bytes_due.size() == 0) begin
        $display("%0t: unexpected row byte, actual line %0d index %0d value %02h row end %0b",
                 $time, got.line_number, got.byte_index, got.byte_value, got.row_end);
        errors++;
        return;
      end
      want = row_bytes_due.pop_front();
      if (got.line_number !== want.line_number) begin
        $display("%0t: line_number expected %0d actual %0d",
                 $time, want.line_number, got.line_number);
        errors++;
      end
      if (got.byte_index !== want.byte_index) begin
        $display("%0t: byte_index expected %0d actual %0d",
                 $time, want.byte_index, got.byte_index);
        errors++;
      end
      if (got.byte_value !== want.byte_value) begin
        $display("%0t: byte_value (line %0d byte %0d) expected %02h actual %02h",
                 $time, want.line_number, want.byte_index, want.byte_value, got.byte_value);
        errors++;
      end
      if (got.row_end !== want.row_end) begin
        $display("%0t: row_end (line %0d byte %0d) expected %0b actual %0b",
                 $time, want.line_number, want.byte_index, want.row_end, got.row_end);
        errors++;
      end
    endfunction
  endclass

  // Clock, reset and every block input start at known values
  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic [1:0]  in_req_type   = REQ_XOR;
  logic [6:0]  in_line       = '0;
  logic [6:0]  in_bit_offset = '0;
  logic [7:0]  in_span_bits  = '0;
  logic [31:0] in_glyph_bits = '0;
  logic        in_send       = 1'b0;
  logic        out_stall     = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_line_number;
  logic [3:0]  out_byte_index;
  logic [7:0]  out_byte_value;
  logic        out_row_end;

  frame_tracker frame_sb = new();
  int           cycle_count = 0;
  // Set for whole stretches in which neither side idles
  bit           calm = 1'b0;
  int           stall_left = 0;

  mono_framebuffer_row_engine #(
    .ROW_BYTES(ROW_BYTES),
    .ROW_COUNT(ROW_COUNT)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_line        (in_line),
    .in_bit_offset  (in_bit_offset),
    .in_span_bits   (in_span_bits),
    .in_glyph_bits  (in_glyph_bits),
    .in_send        (in_send),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_number(out_line_number),
    .out_byte_index (out_byte_index),
    .out_byte_value (out_byte_value),
    .out_row_end    (out_row_end)
  );

  // 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: give up if the run has not finished by the limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Row byte receiver: check each transfer, then hold stall for a freshly drawn number of
  // cycles. The countdown runs whether or not a byte is offered, so stalls land on every
  // phase of the engine's walk.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        frame_sb.check_byte('{out_line_number, out_byte_index, out_byte_value, out_row_end});
        stall_left = calm ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one row operation after a random gap and hold it until the transfer happens.
  // Called at a rising edge; returns at the edge of the transfer with valid still high, so
  // a back-to-back item only rewrites the payload.
  task automatic drive_op(input logic [1:0] req, input logic [6:0] line,
                          input logic [6:0] off, input logic [7:0] span,
                          input logic [31:0] glyph, input logic send);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_line       <= line;
    in_bit_offset <= off;
    in_span_bits  <= span;
    in_glyph_bits <= glyph;
    in_send       <= send;
    do @(posedge clk); while (in_stall);
    frame_sb.note_op(req, line, off, span, glyph, send);
  endtask

  // Drop valid and hold off until every predicted byte has been transferred
  task automatic wait_rows_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (frame_sb.pending() != 0);
  endtask

  initial begin
    logic [1:0]  req;
    logic [6:0]  line;
    logic [6:0]  off;
    logic [7:0]  span;
    logic [31:0] glyph;
    logic        send;
    int          pick;

    // Hold reset, then release it once; the engine's clearing sweep then holds in_stall
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes of every field, every request code, glyph saturation,
    // zero spans, pixels dropped past the row end, and rows modified without sending
    drive_op(REQ_XOR,    7'd0,   7'd0,   8'd32,  32'hFFFF_FFFF, 1'b1);
    drive_op(REQ_XOR,    7'd0,   7'd0,   8'd32,  32'h0000_0000, 1'b1);
    drive_op(REQ_XOR,    7'd127, 7'd127, 8'd32,  32'hA5A5_A5A5, 1'b1);
    drive_op(REQ_XOR,    7'd5,   7'd100, 8'd128, 32'h1234_5678, 1'b1);
    drive_op(REQ_XOR,    7'd5,   7'd40,  8'd0,   32'hFFFF_FFFF, 1'b1);
    drive_op(REQ_XOR,    7'd5,   7'd3,   8'd7,   32'hFFFF_FFFF, 1'b0);
    drive_op(REQ_CLEAR,  7'd5,   7'd0,   8'd0,   32'hFFFF_FFFF, 1'b1);
    drive_op(REQ_CLEAR,  7'd6,   7'd0,   8'd128, 32'h0000_0000, 1'b1);
    drive_op(REQ_CLEAR,  7'd7,   7'd127, 8'd128, 32'h0000_0000, 1'b1);
    drive_op(REQ_CLEAR,  7'd7,   7'd5,   8'd11,  32'h0000_0000, 1'b1);
    drive_op(REQ_FILL,   7'd6,   7'd64,  8'd64,  32'h5A5A_5A5A, 1'b1);
    drive_op(REQ_UNUSED, 7'd7,   7'd0,   8'd128, 32'hFFFF_FFFF, 1'b1);
    drive_op(REQ_UNUSED, 7'd8,   7'd9,   8'd9,   32'hFFFF_FFFF, 1'b0);
    drive_op(REQ_FILL,   7'd127, 7'd127, 8'd128, 32'hFFFF_FFFF, 1'b1);
    drive_op(REQ_XOR,    7'd64,  7'd63,  8'd1,   32'h0000_0001, 1'b1);
    drive_op(REQ_CLEAR,  7'd64,  7'd9,   8'd1,   32'h0000_0000, 1'b0);
    drive_op(REQ_XOR,    7'd64,  7'd8,   8'd33,  32'h8000_0001, 1'b1);
    drive_op(REQ_XOR,    7'd8,   7'd96,  8'd32,  32'hFFFF_FFFF, 1'b1);
    drive_op(REQ_CLEAR,  7'd8,   7'd120, 8'd8,   32'h0000_0000, 1'b1);

    // Hold the sender until the directed rows are all out
    wait_rows_drained();

    // Random: half the items hit a handful of rows so operations stack up on them
    for (int i = 0; i < 370; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == 185) wait_rows_drained();

      pick = $urandom_range(0, 9);
      if (pick < 4)      req = REQ_XOR;
      else if (pick < 7) req = REQ_CLEAR;
      else if (pick < 9) req = REQ_FILL;
      else               req = REQ_UNUSED;

      line = $urandom_range(0, 1) ? 7'($urandom_range(0, 3)) : 7'($urandom_range(0, 127));
      off  = $urandom_range(0, 3) == 0 ? 7'($urandom_range(96, 127))
                                       : 7'($urandom_range(0, 127));

      pick = $urandom_range(0, 19);
      if (pick < 12)      span = 8'($urandom_range(0, 40));
      else if (pick < 17) span = 8'($urandom_range(0, 128));
      else begin
        case ($urandom_range(0, 4))
          0:       span = 8'd0;
          1:       span = 8'd1;
          2:       span = 8'd32;
          3:       span = 8'd33;
          default: span = 8'd128;
        endcase
      end

      pick = $urandom_range(0, 9);
      if (pick == 0)      glyph = 32'h0000_0000;
      else if (pick == 1) glyph = 32'hFFFF_FFFF;
      else                glyph = $urandom;

      send = ($urandom_range(0, 3) != 0);
      drive_op(req, line, off, span, glyph, send);
    end

    // Drain, then watch a while longer for stray bytes
    wait_rows_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (frame_sb.errors == 0 && frame_sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
